>>> design/ffsa_pkg.sv
`timescale 1ns / 1ps

package ffsa_pkg;

  // Default sizing
  localparam int SLOTS_DEF      = 1024;
  localparam int VALUE_BITS_DEF = 30;

  // Fixed field widths
  localparam int SLOT_W = 10;
  localparam int CFG_W  = 11;
  localparam int CNT_W  = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;
  localparam logic [CNT_W-1:0] CNT_MAX   = 16'hFFFF;

  // Item kinds
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_REQ  = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROOT,
    ST_DESC,
    ST_PUSH,
    ST_UP_FIRST,
    ST_UP
  } state_t;

endpackage

>>> design/first_fit_slot_allocator_top.sv
`timescale 1ns / 1ps

// First-fit slot allocator. Slot capacities live in a max tree held in one
// simple dual-port node memory of 2*2^L entries, L = clog2(SLOTS); a node
// stores {valid, capacity} and an empty node is zero. A load beat (mode 0)
// writes a slot and rewrites its L ancestors, one tree level per cycle, and
// it returns no result beat; it also clears the unplaced counter. A request
// beat (mode 1) descends from the root one level per cycle to the leftmost
// slot whose capacity is at least the request, then on a hit reports the
// slot and empties it by climbing back to the root. A request misses when
// no slot fits at all, or when the leftmost fit lies beyond basket_count.
// The memory takes one node read and one node write per cycle; a request
// waits in its push step while the previous result beat waits for
// out_ready. Only the first basket_count slots can be chosen, and empty or
// never-loaded slots never are. in_ready is high only between items. A
// result beat sits in an output register, so the next item is taken while
// it waits. After reset the block clears every node memory entry before it
// takes an item; configuration writes are taken at any time.
module first_fit_slot_allocator_top
  import ffsa_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data,
  // input beats
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [VALUE_BITS-1:0] in_value,
  // result beats
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_placed,
  output logic [SLOT_W-1:0]     out_slot_found,
  output logic [CNT_W-1:0]      out_unplaced_count
);

  localparam int LEVELS = $clog2(SLOTS);
  localparam int ADDR_W = LEVELS + 1;
  localparam int DEPTH  = 2 << LEVELS;
  localparam int NODE_W = VALUE_BITS + 1;

  logic [CFG_W-1:0]  basket_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [NODE_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [NODE_W-1:0] mem_rdata;
  logic [NODE_W-1:0] alu_key;
  logic [NODE_W-1:0] alu_acc;
  logic              alu_fits;
  logic [NODE_W-1:0] alu_max;

  // basket_count register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      basket_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      basket_r <= cfg_data;
    end
  end

  ffsa_seq #(
    .SLOTS      (SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_slot            (in_slot),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_placed         (out_placed),
    .out_slot_found     (out_slot_found),
    .out_unplaced_count (out_unplaced_count),
    .basket_count       (basket_r),
    .mem_we             (mem_we),
    .mem_waddr          (mem_waddr),
    .mem_wdata          (mem_wdata),
    .mem_raddr          (mem_raddr),
    .alu_key            (alu_key),
    .alu_acc            (alu_acc),
    .alu_fits           (alu_fits),
    .alu_max            (alu_max)
  );

  ffsa_node_alu #(
    .NODE_W (NODE_W)
  ) u_alu (
    .rd_node  (mem_rdata),
    .key_node (alu_key),
    .acc_node (alu_acc),
    .fits     (alu_fits),
    .max_node (alu_max)
  );

  ffsa_ram #(
    .WIDTH (NODE_W),
    .DEPTH (DEPTH)
  ) u_nodes (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

endmodule

>>> design/ffsa_ram.sv
`timescale 1ns / 1ps

module ffsa_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/ffsa_node_alu.sv
`timescale 1ns / 1ps

// Shared node unit: fit test on the descent, max merge on the ascent.
// A node is {valid, capacity}; an empty node is all zeros, so a plain
// unsigned compare orders empty below every loaded slot.
module ffsa_node_alu #(
  parameter int NODE_W = 31
) (
  input  logic [NODE_W-1:0] rd_node,
  input  logic [NODE_W-1:0] key_node,
  input  logic [NODE_W-1:0] acc_node,
  output logic              fits,
  output logic [NODE_W-1:0] max_node
);

  assign fits     = (rd_node >= key_node);
  assign max_node = (rd_node > acc_node) ? rd_node : acc_node;

endmodule

>>> design/ffsa_seq.sv
`timescale 1ns / 1ps

module ffsa_seq
  import ffsa_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int LEVELS    = $clog2(SLOTS),
  localparam int ADDR_W    = LEVELS + 1,
  localparam int NODE_W    = VALUE_BITS + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input beats
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [VALUE_BITS-1:0] in_value,
  // result beats
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_placed,
  output logic [SLOT_W-1:0]     out_slot_found,
  output logic [CNT_W-1:0]      out_unplaced_count,
  // configuration
  input  logic [CFG_W-1:0]      basket_count,
  // node memory
  output logic                  mem_we,
  output logic [ADDR_W-1:0]     mem_waddr,
  output logic [NODE_W-1:0]     mem_wdata,
  output logic [ADDR_W-1:0]     mem_raddr,
  // node unit
  output logic [NODE_W-1:0]     alu_key,
  output logic [NODE_W-1:0]     alu_acc,
  input  logic                  alu_fits,
  input  logic [NODE_W-1:0]     alu_max
);

  localparam int IDX_W = LEVELS;
  localparam logic [ADDR_W-1:0] ROOT_ADDR = ADDR_W'(1);

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0]     node_r, node_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  logic [NODE_W-1:0]     acc_r, acc_nxt;
  logic [IDX_W-1:0]      found_r, found_nxt;
  logic                  hit_r, hit_nxt;
  logic [ADDR_W-1:0]     clr_r, clr_nxt;
  logic [CNT_W-1:0]      miss_r, miss_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_placed_r, out_placed_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic [CNT_W-1:0]      out_cnt_r, out_cnt_nxt;

  logic [ADDR_W-1:0] chosen;
  logic              chosen_leaf;
  logic [ADDR_W-1:0] parent;
  logic [31:0]       slot_ext;
  logic              load_ok;
  logic [31:0]       found_ext;
  logic              in_range;
  logic              out_free;
  logic              push_fire;
  logic              in_fire;

  // Descent step: left child if it fits, else its right sibling
  assign chosen      = alu_fits ? node_r : (node_r ^ ROOT_ADDR);
  assign chosen_leaf = chosen[ADDR_W-1];
  assign parent      = node_r >> 1;

  assign slot_ext  = 32'(in_slot);
  assign load_ok   = (slot_ext < 32'(SLOTS));
  assign found_ext = 32'(found_r);
  assign in_range  = hit_r && (found_ext < 32'(basket_count)) && (found_ext < 32'(SLOTS));

  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign push_fire = (state_r == ST_PUSH) && out_free;

  assign alu_key = {1'b1, key_r};
  assign alu_acc = acc_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_REQ) begin
            state_nxt = ST_ROOT;
          end else if (load_ok) begin
            state_nxt = ST_UP_FIRST;
          end
        end
      end
      ST_ROOT: begin
        state_nxt = alu_fits ? ST_DESC : ST_PUSH;
      end
      ST_DESC: begin
        if (chosen_leaf) state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) state_nxt = in_range ? ST_UP_FIRST : ST_IDLE;
      end
      ST_UP_FIRST: begin
        state_nxt = ST_UP;
      end
      ST_UP: begin
        if (parent == ROOT_ADDR) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready           = (state_r == ST_IDLE);
    out_valid          = out_valid_r;
    out_placed         = out_placed_r;
    out_slot_found     = out_slot_r;
    out_unplaced_count = out_cnt_r;
  end

  // Datapath and memory control
  always_comb begin
    node_nxt     = node_r;
    key_nxt      = key_r;
    acc_nxt      = acc_r;
    found_nxt    = found_r;
    hit_nxt      = hit_r;
    clr_nxt      = clr_r;
    miss_nxt     = miss_r;
    out_placed_nxt = out_placed_r;
    out_slot_nxt   = out_slot_r;
    out_cnt_nxt    = out_cnt_r;
    mem_we       = 1'b0;
    mem_waddr    = node_r;
    mem_wdata    = acc_r;
    mem_raddr    = node_r;

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        mem_raddr = ROOT_ADDR;
        if (in_fire) begin
          key_nxt = in_value;
          hit_nxt = 1'b0;
          if (in_mode == MODE_REQ) begin
            node_nxt = ROOT_ADDR;
          end else begin
            miss_nxt = '0;
            node_nxt = {1'b1, slot_ext[IDX_W-1:0]};
            acc_nxt  = {1'b1, in_value};
          end
        end
      end
      ST_ROOT: begin
        mem_raddr = node_r << 1;
        node_nxt  = node_r << 1;
        hit_nxt   = alu_fits;
      end
      ST_DESC: begin
        mem_raddr = chosen << 1;
        node_nxt  = chosen << 1;
        found_nxt = chosen[IDX_W-1:0];
      end
      ST_PUSH: begin
        if (out_free) begin
          out_placed_nxt = in_range;
          if (in_range) begin
            out_slot_nxt = found_ext[SLOT_W-1:0];
            out_cnt_nxt  = miss_r;
            acc_nxt      = '0;
            node_nxt     = {1'b1, found_r};
          end else begin
            out_slot_nxt = '0;
            if (miss_r != CNT_MAX) begin
              miss_nxt    = miss_r + CNT_W'(1);
              out_cnt_nxt = miss_r + CNT_W'(1);
            end else begin
              out_cnt_nxt = miss_r;
            end
          end
        end
      end
      ST_UP_FIRST: begin
        // write the leaf, fetch its sibling
        mem_we    = 1'b1;
        mem_waddr = node_r;
        mem_wdata = acc_r;
        mem_raddr = node_r ^ ROOT_ADDR;
      end
      ST_UP: begin
        // parent = max(child, sibling), fetch the parent's sibling
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = alu_max;
        mem_raddr = parent ^ ROOT_ADDR;
        acc_nxt   = alu_max;
        node_nxt  = parent;
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_comb begin
    if (push_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      miss_r      <= miss_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    node_r       <= node_nxt;
    key_r        <= key_nxt;
    acc_r        <= acc_nxt;
    found_r      <= found_nxt;
    hit_r        <= hit_nxt;
    out_placed_r <= out_placed_nxt;
    out_slot_r   <= out_slot_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

endmodule
